// ----- rtl/core/rme_pkg.sv -----
// ----------------------------------------------------------------------------
// rme_pkg - shared types and constants for the rotation matrix to Euler block
// Matrix item type, CORDIC arctangent table and output rounding helper.
// ----------------------------------------------------------------------------
`default_nettype none

package rme_pkg;

	localparam int IN_W        = 16;
	localparam int THR_W       = 15;
	localparam int Z_W         = 26;
	localparam int OUT_W       = 17;
	localparam int TAB_LEN     = 24;
	localparam int GUARD_SHIFT = 16;
	localparam int RND_SHIFT   = 9;
	localparam int RND_HALF    = 256;

	localparam logic [THR_W-1:0] THR_RESET = 15'd82;

	localparam logic signed [Z_W-1:0]   DEG180  = 26'sd11796480;
	localparam logic signed [OUT_W-1:0] X_LIMIT = 17'sd23040;
	localparam logic signed [OUT_W-1:0] Y_LIMIT = 17'sd11520;

	// atan(2^-i) in degrees * 65536
	localparam logic signed [Z_W-1:0] ATAN_TAB [TAB_LEN] = '{
		26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
		26'sd234379,  26'sd117304,  26'sd58666,  26'sd29335,
		26'sd14668,   26'sd7334,    26'sd3667,   26'sd1833,
		26'sd917,     26'sd458,     26'sd229,    26'sd115,
		26'sd57,      26'sd29,      26'sd14,     26'sd7,
		26'sd4,       26'sd2,       26'sd1,      26'sd0
	};

	typedef struct packed {
		logic signed [IN_W-1:0] r00;
		logic signed [IN_W-1:0] r10;
		logic signed [IN_W-1:0] r20;
		logic signed [IN_W-1:0] r21;
		logic signed [IN_W-1:0] r22;
	} mat_t;

	// degrees*65536 to degrees*128, half away from zero, clamped to +-lim
	function automatic logic signed [OUT_W-1:0] round_deg(
		input logic signed [Z_W-1:0]   z,
		input logic signed [OUT_W-1:0] lim
	);
		logic [Z_W-1:0]          mag;
		logic [OUT_W-1:0]        q;
		logic signed [OUT_W:0]   r;
		logic signed [OUT_W:0]   l;
		mag = z[Z_W-1] ? Z_W'(-z) : Z_W'(z);
		q   = OUT_W'((mag + Z_W'(RND_HALF)) >> RND_SHIFT);
		r   = z[Z_W-1] ? -$signed({1'b0, q}) : $signed({1'b0, q});
		l   = (OUT_W+1)'(lim);
		if (r > l)
			r = l;
		if (r < -l)
			r = -l;
		return OUT_W'(r);
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/rme_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// rme_sqrt_cell - one digit of the integer square root
// Takes two radicand bits, settles one root bit and carries the matrix along.
// ----------------------------------------------------------------------------
`default_nettype none

module rme_sqrt_cell #(
	parameter int FRAC_BITS = 14
) (
	input  wire logic                         clk,
	input  wire logic                         en,
	input  wire logic [2*FRAC_BITS+1:0]       rad,
	input  wire logic [FRAC_BITS+3:0]         rem,
	input  wire logic [FRAC_BITS:0]           root,
	input  wire rme_pkg::mat_t                mat,
	output logic      [2*FRAC_BITS+1:0]       rad_q,
	output logic      [FRAC_BITS+3:0]         rem_q,
	output logic      [FRAC_BITS:0]           root_q,
	output rme_pkg::mat_t                     mat_q
);

	localparam int RAD_W = 2*FRAC_BITS+2;
	localparam int RW    = FRAC_BITS+4;
	localparam int NQ    = FRAC_BITS+1;

	logic [RW-1:0] rem_sh;
	logic [RW-1:0] trial;
	logic [RW-1:0] rem_d;
	logic [NQ-1:0] root_d;

	always_comb begin
		rem_sh = {rem[RW-3:0], rad[RAD_W-1 -: 2]};
		trial  = RW'({root, 2'b01});
		if (rem_sh >= trial) begin
			rem_d  = rem_sh - trial;
			root_d = {root[NQ-2:0], 1'b1};
		end else begin
			rem_d  = rem_sh;
			root_d = {root[NQ-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_q  <= {rad[RAD_W-3:0], 2'b00};
			rem_q  <= rem_d;
			root_q <= root_d;
			mat_q  <= mat;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/rme_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// rme_cordic_cell - one vectoring CORDIC micro-rotation
// Rotates (x, y) towards the x axis by atan(2^-SHIFT), accumulating the angle.
// ----------------------------------------------------------------------------
`default_nettype none

module rme_cordic_cell #(
	parameter int CW    = 34,
	parameter int SHIFT = 0
) (
	input  wire logic                              clk,
	input  wire logic                              en,
	input  wire logic signed [CW-1:0]              x,
	input  wire logic signed [CW-1:0]              y,
	input  wire logic signed [rme_pkg::Z_W-1:0]    z,
	input  wire logic                              zero,
	output logic signed      [CW-1:0]              x_q,
	output logic signed      [CW-1:0]              y_q,
	output logic signed      [rme_pkg::Z_W-1:0]    z_q,
	output logic                                   zero_q
);

	logic signed [CW-1:0]           xs;
	logic signed [CW-1:0]           ys;
	logic signed [CW-1:0]           nx;
	logic signed [CW-1:0]           ny;
	logic signed [rme_pkg::Z_W-1:0] nz;

	always_comb begin
		xs = x >>> SHIFT;
		ys = y >>> SHIFT;
		if (!y[CW-1]) begin
			nx = x + ys;
			ny = y - xs;
			nz = z + rme_pkg::ATAN_TAB[SHIFT];
		end else begin
			nx = x - ys;
			ny = y + xs;
			nz = z - rme_pkg::ATAN_TAB[SHIFT];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_q    <= nx;
			y_q    <= ny;
			z_q    <= nz;
			zero_q <= zero;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/rotation_matrix_to_euler.sv -----
// ----------------------------------------------------------------------------
// rotation_matrix_to_euler - XYZ Euler angles from a Q2.14 rotation matrix
// Square root of 1-r20^2 by digit cells, then three CORDIC lanes per cell row.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel in_valid/in_ready carries r00, r10, r20, r21, r22 (signed
//  fixed point, FRAC_BITS fraction bits). Output channel out_valid/out_ready
//  carries angle_x, angle_y, angle_z (degrees*128) and gimbal_lock.
//  cfg_we writes cfg_wdata into the gimbal threshold at once (reset 82).
//  Pipeline stages, in order: one square stage, FRAC_BITS+1 root-digit
//  cells, one pre-rotation stage, one CORDIC cell per iteration
//  (min(CORDIC_STEPS,24) iterations) and the rounding/output register.
//  Throughput: one request per cycle unless stalled; each stage holds one.
//  Reset clears all valid flags; the pipeline comes up empty.
//  When out_valid is high and out_ready low the whole pipeline holds and
//  in_ready is low; it resumes as soon as the result is taken.
//  Under gimbal lock angle_x and angle_z are 0.
// ----------------------------------------------------------------------------
`default_nettype none

module rotation_matrix_to_euler #(
	parameter int CORDIC_STEPS = 16,
	parameter int FRAC_BITS    = 14
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [15:0] r00,
	input  wire logic signed [15:0] r10,
	input  wire logic signed [15:0] r20,
	input  wire logic signed [15:0] r21,
	input  wire logic signed [15:0] r22,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [15:0]      angle_x,
	output logic signed [14:0]      angle_y,
	output logic signed [15:0]      angle_z,
	output logic                    gimbal_lock,
	input  wire logic               cfg_we,
	input  wire logic [14:0]        cfg_wdata
);

	localparam int NS    = (CORDIC_STEPS < rme_pkg::TAB_LEN) ? CORDIC_STEPS
	                                                          : rme_pkg::TAB_LEN;
	localparam int NQ    = FRAC_BITS + 1;
	localparam int RAD_W = 2*FRAC_BITS + 2;
	localparam int RW    = FRAC_BITS + 4;
	localparam int MAGW  = (FRAC_BITS > 15) ? FRAC_BITS : 15;
	localparam int CW    = MAGW + 19;
	localparam int CMPW  = (NQ > rme_pkg::THR_W) ? NQ : rme_pkg::THR_W;
	localparam int L     = NQ + NS + 3;
	localparam int ZW    = rme_pkg::Z_W;

	localparam logic signed [32:0]  ONE_W   = 33'sd1 <<< FRAC_BITS;
	localparam logic [RAD_W-1:0]    RAD_ONE = RAD_W'(1) << (2*FRAC_BITS);

	logic                      adv;
	logic [L-1:0]              vld_q;
	logic [rme_pkg::THR_W-1:0] thr_q;

	assign adv      = !vld_q[L-1] || out_ready;
	assign in_ready = adv;
	assign out_valid = vld_q[L-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			thr_q <= rme_pkg::THR_RESET;
		end else begin
			if (adv)
				vld_q <= {vld_q[L-2:0], in_valid};
			if (cfg_we)
				thr_q <= cfg_wdata;
		end
	end

	// ---- stage 1: clamp sine, square it
	logic signed [32:0] r20_w;
	logic signed [15:0] r20c;
	logic signed [31:0] prod;
	logic [30:0]        sq_s1;
	rme_pkg::mat_t      mat_s1;

	always_comb begin
		r20_w = 33'(r20);
		if (r20_w > ONE_W)
			r20c = 16'(ONE_W);
		else if (r20_w < -ONE_W)
			r20c = 16'(-ONE_W);
		else
			r20c = r20;
		prod = r20c * r20c;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s1      <= prod[30:0];
			mat_s1.r00 <= r00;
			mat_s1.r10 <= r10;
			mat_s1.r20 <= r20c;
			mat_s1.r21 <= r21;
			mat_s1.r22 <= r22;
		end
	end

	// ---- root-digit cells
	logic [RAD_W-1:0] rad_c  [NQ+1];
	logic [RW-1:0]    rem_c  [NQ+1];
	logic [NQ-1:0]    root_c [NQ+1];
	rme_pkg::mat_t    mat_c  [NQ+1];

	assign rad_c[0]  = RAD_ONE - RAD_W'(sq_s1);
	assign rem_c[0]  = '0;
	assign root_c[0] = '0;
	assign mat_c[0]  = mat_s1;

	for (genvar k = 0; k < NQ; k++) begin : g_sqrt
		rme_sqrt_cell #(.FRAC_BITS(FRAC_BITS)) u_cell (
			.clk    (clk),
			.en     (adv),
			.rad    (rad_c[k]),
			.rem    (rem_c[k]),
			.root   (root_c[k]),
			.mat    (mat_c[k]),
			.rad_q  (rad_c[k+1]),
			.rem_q  (rem_c[k+1]),
			.root_q (root_c[k+1]),
			.mat_q  (mat_c[k+1])
		);
	end

	// ---- pre-rotation: lanes 0 = X, 1 = Y, 2 = Z
	logic signed [CW-1:0] lx [3];
	logic signed [CW-1:0] ly [3];
	logic signed [CW-1:0] cx [NS+1][3];
	logic signed [CW-1:0] cy [NS+1][3];
	logic signed [ZW-1:0] cz [NS+1][3];
	logic                 cz0 [NS+1][3];
	logic                 lock_s2;

	assign lx[0] = CW'(mat_c[NQ].r22);
	assign ly[0] = CW'(mat_c[NQ].r21);
	assign lx[1] = CW'($signed({1'b0, root_c[NQ]}));
	assign ly[1] = CW'(mat_c[NQ].r20);
	assign lx[2] = CW'(mat_c[NQ].r00);
	assign ly[2] = CW'(mat_c[NQ].r10);

	for (genvar l = 0; l < 3; l++) begin : g_prep
		logic signed [CW-1:0] xs;
		logic signed [CW-1:0] ys;
		logic signed [ZW-1:0] zs;

		always_comb begin
			xs = lx[l] <<< rme_pkg::GUARD_SHIFT;
			ys = ly[l] <<< rme_pkg::GUARD_SHIFT;
			zs = '0;
			if (xs[CW-1]) begin
				zs = ys[CW-1] ? -rme_pkg::DEG180 : rme_pkg::DEG180;
				xs = -xs;
				ys = -ys;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				cx[0][l]  <= xs;
				cy[0][l]  <= ys;
				cz[0][l]  <= zs;
				cz0[0][l] <= (lx[l] == '0) && (ly[l] == '0);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			lock_s2 <= CMPW'(root_c[NQ]) <= CMPW'(thr_q);
	end

	// ---- CORDIC cells
	for (genvar i = 0; i < NS; i++) begin : g_cordic
		for (genvar l = 0; l < 3; l++) begin : g_lane
			rme_cordic_cell #(.CW(CW), .SHIFT(i)) u_cell (
				.clk    (clk),
				.en     (adv),
				.x      (cx[i][l]),
				.y      (cy[i][l]),
				.z      (cz[i][l]),
				.zero   (cz0[i][l]),
				.x_q    (cx[i+1][l]),
				.y_q    (cy[i+1][l]),
				.z_q    (cz[i+1][l]),
				.zero_q (cz0[i+1][l])
			);
		end
	end

	logic [NS-1:0] lock_q;

	always_ff @(posedge clk) begin
		if (adv)
			lock_q <= {lock_q[NS-2:0], lock_s2};
	end

	// ---- rounding and output register
	logic signed [rme_pkg::OUT_W-1:0] ax_d;
	logic signed [rme_pkg::OUT_W-1:0] ay_d;
	logic signed [rme_pkg::OUT_W-1:0] az_d;

	always_comb begin
		ax_d = rme_pkg::round_deg(cz[NS][0], rme_pkg::X_LIMIT);
		ay_d = rme_pkg::round_deg(cz[NS][1], rme_pkg::Y_LIMIT);
		az_d = rme_pkg::round_deg(cz[NS][2], rme_pkg::X_LIMIT);
		if (cz0[NS][0] || lock_q[NS-1])
			ax_d = '0;
		if (cz0[NS][1])
			ay_d = '0;
		if (cz0[NS][2] || lock_q[NS-1])
			az_d = '0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			angle_x     <= 16'(ax_d);
			angle_y     <= 15'(ay_d);
			angle_z     <= 16'(az_d);
			gimbal_lock <= lock_q[NS-1];
		end
	end

	// ---- checks
	a_lock_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && gimbal_lock |-> angle_x == 16'sd0 && angle_z == 16'sd0)
		else $error("X/Z angle not zero under gimbal lock");

	a_y_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> angle_y >= -15'sd11520 && angle_y <= 15'sd11520)
		else $error("Y angle out of range");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input held off without a stalled result");

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench - rotation matrix to Euler angles
// Table of directed matrices, then random matrices under random idling on
// both channels; every result is checked against a CORDIC predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY   = 34;
	localparam int WD_LIMIT  = 4000;
	localparam int N_RANDOM  = 1150;
	localparam int ONE       = 16384;
	localparam int STEPS     = 16;

	typedef struct packed {
		logic signed [15:0] ax;
		logic signed [14:0] ay;
		logic signed [15:0] az;
		logic               lock;
	} angles_t;

	typedef struct {
		rme_pkg::mat_t m;
		bit            known;
		angles_t       res;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [15:0] r00 = '0, r10 = '0, r20 = '0, r21 = '0, r22 = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [15:0] angle_x;
	logic signed [14:0] angle_y;
	logic signed [15:0] angle_z;
	logic gimbal_lock;
	logic cfg_we = 1'b0;
	logic [14:0] cfg_wdata = '0;

	angles_t expected_angles[$];
	longint  threshold = 82;
	int      mismatches = 0;
	int      idle_cycles = 0;
	bit      quiet = 1'b0;
	bit      stall_on = 1'b1;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	rotation_matrix_to_euler DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.r00(r00), .r10(r10), .r20(r20), .r21(r21), .r22(r22),
		.out_valid(out_valid), .out_ready(out_ready),
		.angle_x(angle_x), .angle_y(angle_y), .angle_z(angle_z),
		.gimbal_lock(gimbal_lock),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	function automatic longint floor_shr(longint v, int s);
		if (v >= 0)
			return v >>> s;
		return -(((-v) - 1) >>> s) - 1;
	endfunction

	function automatic longint cordic_deg(longint y, longint x);
		longint z, nx, xs, ys;
		z = 0;
		if (x == 0 && y == 0)
			return 0;
		x = x * 65536;
		y = y * 65536;
		if (x < 0) begin
			z = (y >= 0) ? longint'(rme_pkg::DEG180) : -longint'(rme_pkg::DEG180);
			x = -x;
			y = -y;
		end
		for (int i = 0; i < STEPS; i++) begin
			xs = floor_shr(x, i);
			ys = floor_shr(y, i);
			if (y >= 0) begin
				nx = x + ys;
				y  = y - xs;
				z += longint'(rme_pkg::ATAN_TAB[i]);
			end else begin
				nx = x - ys;
				y  = y + xs;
				z -= longint'(rme_pkg::ATAN_TAB[i]);
			end
			x = nx;
		end
		return z;
	endfunction

	function automatic longint deg128(longint z, longint lim);
		longint r;
		r = (z >= 0) ? (z + 256) / 512 : -((-z + 256) / 512);
		if (r > lim)
			r = lim;
		if (r < -lim)
			r = -lim;
		return r;
	endfunction

	function automatic longint root_floor(longint v);
		longint r;
		r = 0;
		while ((r + 1) * (r + 1) <= v)
			r++;
		return r;
	endfunction

	function automatic angles_t euler_from_matrix(rme_pkg::mat_t m);
		angles_t a;
		longint s, c;
		s = m.r20;
		if (s > ONE)
			s = ONE;
		if (s < -ONE)
			s = -ONE;
		c = root_floor(longint'(ONE) * ONE - s * s);
		a.lock = (c <= threshold);
		a.ay = 15'(deg128(cordic_deg(s, c), 11520));
		a.ax = '0;
		a.az = '0;
		if (!a.lock) begin
			a.ax = 16'(deg128(cordic_deg(m.r21, m.r22), 23040));
			a.az = 16'(deg128(cordic_deg(m.r10, m.r00), 23040));
		end
		return a;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d, expected %0d", what, got, want);
		mismatches++;
	endtask

	// output side: random stalls, check on accept
	always @(posedge clk) begin
		angles_t e;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_angles.size() == 0) begin
					report_mismatch("unexpected result", 0, 0);
				end else begin
					e = expected_angles.pop_front();
					if (angle_x !== e.ax)
						report_mismatch("angle_x", angle_x, e.ax);
					if (angle_y !== e.ay)
						report_mismatch("angle_y", angle_y, e.ay);
					if (angle_z !== e.az)
						report_mismatch("angle_z", angle_z, e.az);
					if (gimbal_lock !== e.lock)
						report_mismatch("gimbal_lock", gimbal_lock, e.lock);
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WD_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin : out_stall
		int n;
		forever begin
			@(posedge clk);
			if (!quiet && stall_on && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 16);
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	task automatic send_matrix(rme_pkg::mat_t m, bit known, angles_t res);
		angles_t p;
		int n;
		if (!quiet && $urandom_range(0, 7) == 0) begin
			n = $urandom_range(1, 16);
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		in_valid <= 1'b1;
		{r00, r10, r20, r21, r22} <= m;
		do @(posedge clk); while (!in_ready);
		p = euler_from_matrix(m);
		if (known && p != res)
			report_mismatch("table row vs predictor", p, res);
		expected_angles.insert(expected_angles.size(), known ? res : p);
	endtask

	task automatic end_request;
		in_valid <= 1'b0;
	endtask

	task automatic drain;
		end_request();
		@(posedge clk);
		while (expected_angles.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_threshold(logic [14:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		threshold = v;
	endtask

	function automatic logic signed [15:0] rnd_entry();
		case ($urandom_range(0, 9))
			0: return 16'($urandom);
			1: return 16'sd16384;
			2: return -16'sd16384;
			default: return 16'($signed($urandom_range(0, 32768)) - 16384);
		endcase
	endfunction

	function automatic rme_pkg::mat_t rnd_matrix();
		rme_pkg::mat_t m;
		m.r00 = rnd_entry();
		m.r10 = rnd_entry();
		m.r21 = rnd_entry();
		m.r22 = rnd_entry();
		case ($urandom_range(0, 5))
			0: m.r20 = 16'($signed($urandom_range(16300, 16384)));
			1: m.r20 = -16'($signed($urandom_range(16300, 16384)));
			default: m.r20 = rnd_entry();
		endcase
		return m;
	endfunction

	row_t table_rows[$];

	function automatic row_t mk(int a, int b, int c, int d, int e, bit k,
			int x, int y, int z, bit l);
		row_t t;
		t.m = '{16'(a), 16'(b), 16'(c), 16'(d), 16'(e)};
		t.known = k;
		t.res = '{16'(x), 15'(y), 16'(z), l};
		return t;
	endfunction

	function automatic void add_row(row_t r);
		table_rows.insert(table_rows.size(), r);
	endfunction

	initial begin
		rme_pkg::mat_t m;
		angles_t none;
		none = '0;
		// identity and zero vectors
		add_row(mk(16384, 0, 0, 0, 16384, 1, 0, 0, 0, 0));
		add_row(mk(0, 0, 0, 0, 0, 1, 0, 0, 0, 0));
		// gimbal lock at both poles
		add_row(mk(0, 0, 16384, 0, 0, 1, 0, 11520, 0, 1));
		add_row(mk(0, 0, -16384, 0, 0, 1, 0, -11520, 0, 1));
		// sine beyond one saturates
		add_row(mk(100, 200, 32767, 300, 400, 1, 0, 11520, 0, 1));
		add_row(mk(100, 200, -32768, 300, 400, 1, 0, -11520, 0, 1));
		add_row(mk(-16384, 0, 0, 0, -16384, 0, 0, 0, 0, 0));
		add_row(mk(-16384, -1, 0, -1, -16384, 0, 0, 0, 0, 0));
		add_row(mk(-16384, 1, 0, 1, -16384, 0, 0, 0, 0, 0));
		add_row(mk(0, 16384, 0, -16384, 0, 0, 0, 0, 0, 0));
		add_row(mk(-32768, 32767, 11585, 32767, -32768, 0, 0, 0, 0, 0));
		add_row(mk(32767, -32768, -11585, -32768, 32767, 0, 0, 0, 0, 0));
		add_row(mk(5, -7, 16383, 9, -3, 0, 0, 0, 0, 0));
		add_row(mk(5, -7, 16380, 9, -3, 0, 0, 0, 0, 0));
		add_row(mk(-5, 7, -16370, -9, 3, 0, 0, 0, 0, 0));
		add_row(mk(11585, 11585, 0, 11585, 11585, 0, 0, 0, 0, 0));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (table_rows[i])
			send_matrix(table_rows[i].m, table_rows[i].known, table_rows[i].res);
		drain();

		// threshold sweep: extremes and a few in between
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: write_threshold(15'd0);
				1: write_threshold(15'd16384);
				2: write_threshold(15'h7FFF);
				3: write_threshold(15'($urandom_range(0, 2000)));
				4: write_threshold(15'($urandom));
				default: write_threshold(rme_pkg::THR_RESET);
			endcase
			for (int i = 0; i < N_RANDOM / 6; i++) begin
				if (ph == 5 && i > N_RANDOM / 12)
					quiet = 1'b1;
				m = rnd_matrix();
				send_matrix(m, 1'b0, none);
			end
			drain();
		end

		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

`default_nettype wire
